[rtl/u8dec_pkg.sv]
// Package for the UTF-8 stream decoder: codepoint constants, decode limits
// and the descriptor word passed from the front end to the emitter.
// No dependencies.
`default_nettype none

package u8dec_pkg;

  localparam int CP_W     = 21;
  localparam int NREP_W   = 3;
  localparam int Q_DEPTH  = 4;

  localparam logic [CP_W-1:0] REPL_CP   = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;
  localparam logic [CP_W-1:0] PV_ED     = 21'h00D000;
  localparam logic [CP_W-1:0] PV_F4_MIN = 21'h100000;

  // Lowest payload of a two-byte lead (C2) and first bad payload of a four-byte lead (F5)
  localparam logic [4:0] LEAD2_MIN = 5'h02;
  localparam logic [2:0] LEAD4_BAD = 3'h5;
  // Second-byte bounds after E0/ED and F0/F4
  localparam logic [5:0] CONT3_BOUND = 6'h20;
  localparam logic [5:0] CONT4_BOUND = 6'h10;

  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // One word per input byte or flush that yields output: n_rep replacements, then
  // optionally one decoded codepoint.
  typedef struct packed {
    logic [NREP_W-1:0] n_rep;
    logic              has_cp;
    logic [CP_W-1:0]   cp;
  } desc_t;

endpackage

`default_nettype wire

[rtl/u8dec_front.sv]
// Front end of the UTF-8 decoder: accepts bytes, tracks the sequence state
// and turns each byte into one descriptor word. Uses u8dec_pkg.
`default_nettype none

module u8dec_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_op,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              q_full,
  output logic                   push,
  output u8dec_pkg::desc_t       push_desc
);
  import u8dec_pkg::*;

  logic [2:0]      needed_r, needed_nxt;
  logic [1:0]      held_r, held_nxt;
  logic [CP_W-1:0] pv_r, pv_nxt;

  logic            accept;
  logic [5:0]      d;
  logic [CP_W-1:0] d_ext;
  logic [CP_W-1:0] d_shift;
  logic [CP_W-1:0] pv_acc;
  logic [2:0]      held_inc;
  logic [2:0]      gap;
  logic            bad2;
  logic            extra_rep;
  desc_t           desc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign d        = in_data_byte[5:0];
  assign d_ext    = {{(CP_W-6){1'b0}}, d};
  assign held_inc = {1'b0, held_r} + 3'd1;
  assign gap      = needed_r - held_inc;

  always_comb begin
    unique case (gap[1:0])
      2'd0: d_shift = d_ext;
      2'd1: d_shift = d_ext << 6;
      2'd2: d_shift = d_ext << 12;
      2'd3: d_shift = d_ext << 18;
    endcase
  end

  assign pv_acc = pv_r | d_shift;

  always_comb begin
    bad2 = 1'b0;
    if (needed_r == LEN_3) begin
      bad2 = (held_r == 2'd1) &&
             ((pv_r == '0 && d < CONT3_BOUND) || (pv_r == PV_ED && d >= CONT3_BOUND));
    end else if (needed_r == LEN_4) begin
      bad2 = (held_r == 2'd1) &&
             ((pv_r == '0 && d < CONT4_BOUND) || (pv_r >= PV_F4_MIN && d >= CONT4_BOUND));
    end
  end

  always_comb begin
    needed_nxt  = needed_r;
    held_nxt    = held_r;
    pv_nxt      = pv_r;
    extra_rep   = 1'b0;
    desc.n_rep  = '0;
    desc.has_cp = 1'b0;
    desc.cp     = REPL_CP;
    if (in_op == OP_FLUSH) begin
      desc.n_rep = {1'b0, held_r};
      needed_nxt = '0;
      held_nxt   = '0;
    end else if (in_data_byte[7:6] == 2'b10) begin
      needed_nxt = '0;
      held_nxt   = '0;
      priority if (needed_r != LEN_2 && needed_r != LEN_3 && needed_r != LEN_4) begin
        desc.n_rep = 3'd1;
      end else if (bad2) begin
        desc.n_rep = 3'd2;
      end else if ({1'b0, held_r} >= needed_r) begin
        desc.n_rep = 3'd1;
      end else if (held_inc == needed_r) begin
        desc.has_cp = 1'b1;
        desc.cp     = pv_acc;
        pv_nxt      = pv_acc;
      end else begin
        // advance the sequence, nothing to emit yet
        needed_nxt = needed_r;
        held_nxt   = held_inc[1:0];
        pv_nxt     = pv_acc;
      end
    end else begin
      // lead byte: drain whatever is buffered first
      needed_nxt = '0;
      held_nxt   = '0;
      priority if (!in_data_byte[7]) begin
        desc.has_cp = 1'b1;
        desc.cp     = {{(CP_W-8){1'b0}}, in_data_byte};
      end else if (in_data_byte[7:5] == 3'b110) begin
        if (in_data_byte[4:0] < LEAD2_MIN) begin
          extra_rep = 1'b1;
        end else begin
          needed_nxt = LEN_2;
          held_nxt   = 2'd1;
          pv_nxt     = {{(CP_W-11){1'b0}}, in_data_byte[4:0], 6'b0};
        end
      end else if (in_data_byte[7:4] == 4'b1110) begin
        needed_nxt = LEN_3;
        held_nxt   = 2'd1;
        pv_nxt     = {{(CP_W-16){1'b0}}, in_data_byte[3:0], 12'b0};
      end else if (in_data_byte[7:3] == 5'b11110) begin
        if (in_data_byte[2:0] >= LEAD4_BAD) begin
          extra_rep = 1'b1;
        end else begin
          needed_nxt = LEN_4;
          held_nxt   = 2'd1;
          pv_nxt     = {in_data_byte[2:0], 18'b0};
        end
      end else begin
        extra_rep = 1'b1;
      end
      desc.n_rep = {1'b0, held_r} + {2'b0, extra_rep};
    end
  end

  assign push      = accept && (desc.n_rep != '0 || desc.has_cp);
  assign push_desc = desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needed_r <= '0;
      held_r   <= '0;
      pv_r     <= '0;
    end else if (accept) begin
      needed_r <= needed_nxt;
      held_r   <= held_nxt;
      pv_r     <= pv_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/u8dec_fifo.sv]
// Descriptor queue between the decoder front end and the emitter.
// Register-based, DEPTH entries. Uses u8dec_pkg.
`default_nettype none

module u8dec_fifo #(
  parameter int DEPTH = u8dec_pkg::Q_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire u8dec_pkg::desc_t  push_desc,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output u8dec_pkg::desc_t       head_desc
);
  import u8dec_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_desc  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("descriptor pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("descriptor popped from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

[rtl/u8dec_back.sv]
// Emitter of the UTF-8 decoder (uses u8dec_pkg): expands each descriptor
// word into codepoints in the output register, one per cycle unless held.
`default_nettype none

module u8dec_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       head_valid,
  input  wire u8dec_pkg::desc_t           head_desc,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [u8dec_pkg::CP_W-1:0]      out_codepoint,
  output logic                            out_last
);
  import u8dec_pkg::*;

  logic [NREP_W-1:0] sent_r, sent_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CP_W-1:0]   out_cp_r, out_cp_nxt;
  logic              out_last_r, out_last_nxt;
  logic              load;
  logic              emit;
  logic [NREP_W-1:0] total;
  logic [NREP_W-1:0] sent_inc;
  logic              is_last;

  assign load     = !out_valid_r || out_ready;
  assign emit     = load && head_valid;
  assign total    = head_desc.n_rep + {{(NREP_W-1){1'b0}}, head_desc.has_cp};
  assign sent_inc = sent_r + 1'b1;
  assign is_last  = (sent_inc == total);
  assign pop      = emit && is_last;

  always_comb begin
    sent_nxt      = sent_r;
    out_valid_nxt = out_valid_r;
    out_cp_nxt    = out_cp_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = head_valid;
    end
    if (emit) begin
      // replacements go out first, the decoded value last
      out_cp_nxt   = (sent_r < head_desc.n_rep) ? REPL_CP : head_desc.cp;
      out_last_nxt = is_last;
      sent_nxt     = is_last ? '0 : sent_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cp_r   <= out_cp_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_codepoint = out_cp_r;
  assign out_last      = out_last_r;

  a_sent_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> sent_r < total) else $error("emit index past descriptor");
  a_sent_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> sent_r == '0) else $error("emit index held with empty queue");
  a_cp_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cp_r <= MAX_CP) else $error("codepoint above U+10FFFF");

endmodule

`default_nettype wire

[rtl/utf8_stream_decoder.sv]
// UTF-8 stream decoder, top level: front end, descriptor queue, emitter.
// Depends on u8dec_pkg, u8dec_front, u8dec_fifo and u8dec_back.
//
// Takes one byte (or a flush) per word on the in_ channel and returns
// Unicode codepoints, one per word on the out_ channel, with out_last set on
// the final codepoint caused by an input word; bytes that only extend a
// sequence, and flushes with nothing buffered, produce no output. Errors give
// U+FFFD. A byte is taken every cycle as long as the QDEPTH-entry descriptor
// queue has room; the emitter sends one codepoint per cycle while out_ready
// allows; a word yielding n codepoints (n is 0 to 4) takes n output words,
// and the queue absorbs such bursts. The first codepoint of a word enters
// the queue, then the output register. No initialization pass after reset.
`default_nettype none

module utf8_stream_decoder #(
  parameter int QDEPTH = u8dec_pkg::Q_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_op,
  input  wire logic [7:0]             in_data_byte,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [u8dec_pkg::CP_W-1:0]  out_codepoint,
  output logic                        out_last
);
  import u8dec_pkg::*;

  logic  q_full;
  logic  push;
  desc_t push_desc;
  logic  pop;
  logic  head_valid;
  desc_t head_desc;

  u8dec_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .push         (push),
    .push_desc    (push_desc)
  );

  u8dec_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  u8dec_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_desc     (head_desc),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_codepoint (out_codepoint),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire
